FILE: sv/dlce_pkg.sv
`timescale 1ns / 1ps

package dlce_pkg;

    localparam logic [1:0] CMD_LINK   = 2'd0;
    localparam logic [1:0] CMD_UNLINK = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_BWD,
        S_COLLECT,
        S_ERD,
        S_ELOAD,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] first_node;
        logic [5:0] second_node;
    } t_in_item;

    typedef struct packed {
        logic [5:0] member_node;
        logic [6:0] chain_length;
        logic       last_member;
        logic       loop_error;
    } t_out_item;

endpackage

FILE: sv/dlce_ram.sv
`timescale 1ns / 1ps

module dlce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/dlce_link_table.sv
`timescale 1ns / 1ps

module dlce_link_table #(
    parameter int NODES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_wr_link,
    input  logic [$clog2(NODES)-1:0] i_wr_front,
    input  logic [$clog2(NODES)-1:0] i_wr_rear,
    input  logic                     i_rd_en,
    input  logic                     i_rd_prev,
    input  logic [$clog2(NODES)-1:0] i_rd_node,
    output logic                     o_linked,
    output logic [$clog2(NODES)-1:0] o_rd_node
);

    localparam int AW = $clog2(NODES);

    logic [NODES-1:0] r_next_ok;
    logic [NODES-1:0] r_prev_ok;
    logic [AW-1:0]    next_q;
    logic [AW-1:0]    prev_q;
    logic             link_we;

    assign link_we = i_wr_en && i_wr_link;

    // a flag per entry marks a live link, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ok <= '0;
            r_prev_ok <= '0;
        end else if (i_wr_en) begin
            r_next_ok[i_wr_front] <= i_wr_link;
            r_prev_ok[i_wr_rear]  <= i_wr_link;
        end
    end

    dlce_ram #(
        .WIDTH (AW),
        .DEPTH (NODES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (i_wr_front),
        .i_wdata (i_wr_rear),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_node),
        .o_rdata (next_q)
    );

    dlce_ram #(
        .WIDTH (AW),
        .DEPTH (NODES)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (i_wr_rear),
        .i_wdata (i_wr_front),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_node),
        .o_rdata (prev_q)
    );

    assign o_linked  = i_rd_prev ? r_prev_ok[i_rd_node] : r_next_ok[i_rd_node];
    assign o_rd_node = i_rd_prev ? prev_q : next_q;

endmodule

FILE: sv/doubly_linked_chain_engine.sv
`timescale 1ns / 1ps
// link and unlink: handled in idle, no result transfer
// list: forward walk, backward walk, then collect walk, one link table read per cycle,
// then a buffer read, and per result a load state and an output state held until ready
// input ready only while idle
// synchronous active-low reset clears all links and the sequencer

module doubly_linked_chain_engine #(
    parameter int NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dlce_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dlce_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(NODES);
    localparam int SW = $clog2(2 * NODES);
    localparam logic [AW-1:0] KLAST = AW'(NODES - 1);
    localparam logic [SW-1:0] SCAP  = SW'(NODES - 1);

    dlce_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_first, n_first;
    logic [AW-1:0]       r_cur, n_cur;
    logic                r_chain, n_chain;
    logic [AW-1:0]       r_k, n_k;
    logic [SW-1:0]       r_steps, n_steps;
    logic                r_err, n_err;
    logic [AW-1:0]       r_last, n_last;
    logic [AW-1:0]       r_j, n_j;
    logic                r_ovalid, n_ovalid;
    dlce_pkg::t_out_item r_out, n_out;

    logic          in_xfer;
    logic          out_xfer;
    logic          a_ok;
    logic          b_ok;
    logic          walking;
    logic          tbl_wr_en;
    logic          tbl_rd_en;
    logic          tbl_linked;
    logic [AW-1:0] tbl_rd_node;
    logic [AW-1:0] walk_node;
    logic          walk_go;
    logic          buf_we;
    logic          buf_re;
    logic [AW-1:0] buf_raddr;
    logic [AW-1:0] buf_rdata;

    assign o_in_ready  = (r_state == dlce_pkg::S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_ovalid && i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign a_ok = int'(i_in_data.first_node) < NODES;
    assign b_ok = int'(i_in_data.second_node) < NODES;

    assign walking = (r_state == dlce_pkg::S_FWD) || (r_state == dlce_pkg::S_BWD)
                  || (r_state == dlce_pkg::S_COLLECT);
    assign walk_node = r_chain ? tbl_rd_node : r_cur;
    assign walk_go   = tbl_linked && (r_k != KLAST);

    dlce_link_table #(
        .NODES (NODES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (tbl_wr_en),
        .i_wr_link  (i_in_data.cmd == dlce_pkg::CMD_LINK),
        .i_wr_front (AW'(i_in_data.first_node)),
        .i_wr_rear  (AW'(i_in_data.second_node)),
        .i_rd_en    (tbl_rd_en),
        .i_rd_prev  (r_state == dlce_pkg::S_BWD),
        .i_rd_node  (walk_node),
        .o_linked   (tbl_linked),
        .o_rd_node  (tbl_rd_node)
    );

    dlce_ram #(
        .WIDTH (AW),
        .DEPTH (NODES)
    ) u_member_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_k),
        .i_wdata (walk_node),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dlce_pkg::S_IDLE: begin
                if (in_xfer && (i_in_data.cmd == dlce_pkg::CMD_LIST) && a_ok) begin
                    n_state = dlce_pkg::S_FWD;
                end
            end
            dlce_pkg::S_FWD: begin
                if (!walk_go) begin
                    n_state = dlce_pkg::S_BWD;
                end
            end
            dlce_pkg::S_BWD: begin
                if (!walk_go) begin
                    n_state = dlce_pkg::S_COLLECT;
                end
            end
            dlce_pkg::S_COLLECT: begin
                if (!walk_go) begin
                    n_state = dlce_pkg::S_ERD;
                end
            end
            dlce_pkg::S_ERD: begin
                n_state = dlce_pkg::S_ELOAD;
            end
            dlce_pkg::S_ELOAD: begin
                n_state = dlce_pkg::S_EOUT;
            end
            dlce_pkg::S_EOUT: begin
                if (out_xfer) begin
                    n_state = (r_j == r_last) ? dlce_pkg::S_IDLE : dlce_pkg::S_ELOAD;
                end
            end
            default: begin
                n_state = dlce_pkg::S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_first  = r_first;
        n_cur    = r_cur;
        n_chain  = r_chain;
        n_k      = r_k;
        n_steps  = r_steps;
        n_err    = r_err;
        n_last   = r_last;
        n_j      = r_j;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        case (r_state)
            dlce_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_first = AW'(i_in_data.first_node);
                    n_cur   = AW'(i_in_data.first_node);
                    n_chain = 1'b0;
                    n_k     = '0;
                    n_steps = '0;
                    n_err   = 1'b0;
                end
            end
            dlce_pkg::S_FWD, dlce_pkg::S_BWD, dlce_pkg::S_COLLECT: begin
                n_cur = walk_node;
                if (walk_go) begin
                    n_chain = 1'b1;
                    n_k     = r_k + 1'b1;
                    if (r_state != dlce_pkg::S_COLLECT) begin
                        n_steps = r_steps + 1'b1;
                    end
                end else begin
                    n_chain = 1'b0;
                    n_k     = '0;
                    n_err   = r_err || tbl_linked;
                    if (r_state == dlce_pkg::S_FWD) begin
                        n_cur = r_first;
                    end
                    if (r_state == dlce_pkg::S_COLLECT) begin
                        n_last = r_k;
                        n_j    = '0;
                    end
                end
            end
            dlce_pkg::S_ELOAD: begin
                n_ovalid           = 1'b1;
                n_out.member_node  = 6'(buf_rdata);
                n_out.chain_length = (r_steps >= SCAP) ? 7'(NODES) : 7'(r_steps) + 7'd1;
                n_out.last_member  = (r_j == r_last);
                n_out.loop_error   = r_err;
            end
            dlce_pkg::S_EOUT: begin
                if (out_xfer) begin
                    n_ovalid = 1'b0;
                    if (r_j != r_last) begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    // memory controls
    always_comb begin
        tbl_wr_en = in_xfer && a_ok && b_ok
                 && ((i_in_data.cmd == dlce_pkg::CMD_LINK)
                  || (i_in_data.cmd == dlce_pkg::CMD_UNLINK));
        tbl_rd_en = walking && walk_go;
        buf_we    = (r_state == dlce_pkg::S_COLLECT);
        buf_re    = (r_state == dlce_pkg::S_ERD)
                 || ((r_state == dlce_pkg::S_EOUT) && out_xfer && (r_j != r_last));
        buf_raddr = (r_state == dlce_pkg::S_ERD) ? r_j : r_j + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dlce_pkg::S_IDLE;
            r_chain  <= 1'b0;
            r_k      <= '0;
            r_steps  <= '0;
            r_err    <= 1'b0;
            r_last   <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_k      <= n_k;
            r_steps  <= n_steps;
            r_err    <= n_err;
            r_last   <= n_last;
            r_j      <= n_j;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_cur   <= n_cur;
        r_out   <= n_out;
    end

    a_valid_in_eout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == dlce_pkg::S_EOUT))
        else $error("result valid outside output state");

    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dlce_pkg::S_EOUT) |-> (r_j <= r_last))
        else $error("emit index past chain end");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_out.last_member) |=> (r_state == dlce_pkg::S_IDLE))
        else $error("list did not end after tail transfer");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SW'(2 * (NODES - 1)))
        else $error("step count beyond both walk caps");

endmodule
